[rtl/fsmon_pkg.sv]
// Shared types and constants for the frequency stability monitor.
// Holds field widths, saturation limits, register indexes and the divider request type.
// No dependencies.
package fsmon_pkg;

    localparam int FREQ_BITS     = 22;
    localparam int ROC_BITS      = 24;
    localparam int CFG_BITS      = 8;
    localparam int SR_BITS       = 16;
    localparam int FREQ_DVD_BITS = 24;
    // |frequency difference| (22 bits) times the sample rate (16 bits)
    localparam int PROD_BITS     = FREQ_BITS + SR_BITS;
    localparam int ITER_BITS     = 6;
    localparam int MUL_CNT_BITS  = 5;
    localparam int MAG_BITS      = ROC_BITS - 1;

    localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
    localparam logic [MAG_BITS-1:0]  ROC_MAX  = {MAG_BITS{1'b1}};

    // Quotient bits produced for the frequency and for the rate of change
    localparam logic [ITER_BITS-1:0] FREQ_ITERS = ITER_BITS'(FREQ_DVD_BITS);
    localparam logic [ITER_BITS-1:0] ROC_ITERS  = ITER_BITS'(PROD_BITS);

    // Configuration register indexes
    localparam logic REG_FREQ_THR = 1'b0;
    localparam logic REG_ROC_THR  = 1'b1;

    localparam logic [CFG_BITS-1:0] FREQ_THR_RESET = 8'd50;
    localparam logic [CFG_BITS-1:0] ROC_THR_RESET  = 8'd15;

    typedef struct packed {
        logic                 start;
        logic [ITER_BITS-1:0] iters;
    } div_req_t;

endpackage

[rtl/fsmon_div.sv]
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on fsmon_pkg for the operand widths and the request struct.
module fsmon_div
    import fsmon_pkg::*;
#(
    parameter int DIVISOR_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  div_req_t                req,
    input  logic [PROD_BITS-1:0]    dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output logic [PROD_BITS-1:0]    quotient,
    output logic                    done
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [ITER_BITS-1:0]    cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]    dvd_reg, dvd_next;
    logic [PROD_BITS-1:0]    quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    // The remainder always stays below the divisor, so it fits DIVISOR_BITS.
    assign trial = {rem_reg, dvd_reg[PROD_BITS-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[PROD_BITS-2:0], 1'b0};
            quo_next = {quo_reg[PROD_BITS-2:0], fits};
            rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/fsmon_mul.sv]
// Bit-serial shift-and-add multiplier: one multiplicand bit per clock cycle.
// Depends on fsmon_pkg for the operand and product widths.
module fsmon_mul
    import fsmon_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [FREQ_BITS-1:0] multiplicand,
    input  logic [SR_BITS-1:0]   multiplier,
    output logic [PROD_BITS-1:0] product,
    output logic                 done
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [FREQ_BITS-1:0]    a_reg, a_next;
    logic [SR_BITS-1:0]      b_reg, b_next;
    logic [PROD_BITS-1:0]    acc_reg, acc_next;

    // Multiplicand bits enter from the top, so the sum is shifted up each cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_BITS'(FREQ_BITS);
            a_next    = multiplicand;
            b_next    = multiplier;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = {acc_reg[PROD_BITS-2:0], 1'b0}
                     + (a_reg[FREQ_BITS-1] ? PROD_BITS'(b_reg) : '0);
            a_next   = {a_reg[FREQ_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

[rtl/frequency_stability_monitor_top.sv]
// Top level of the frequency stability monitor: sequencer, thresholds and output register.
// Depends on fsmon_pkg, fsmon_div and fsmon_mul.
//
//  Channel   Direction  Handshake         Carries
//  s_*       in         s_valid/s_ready   sample count of one mains period
//  m_*       out        m_valid/m_ready   frequency, rate of change, stable flag
//  cfg_*     in         cfg_we only       frequency and rate thresholds
//
// The time from acceptance to result is set by the serial divider, which produces one
// quotient bit a cycle and runs twice (24 bits for the frequency, 38 bits for the rate),
// and by the serial multiplier, which works through the 22 multiplicand bits.
// Reset is synchronous and active low; it restores the thresholds to 50 Hz and
// 15 Hz/s and clears the previous frequency, so the first result shows a large rate.
// A new count is taken only once the previous one has been worked through; a finished
// result may still sit in the output register, waiting on m_ready, while the next
// count is accepted and processed.
module frequency_stability_monitor_top
    import fsmon_pkg::*;
#(
    parameter int COUNT_BITS  = 12,
    parameter int SAMPLE_RATE = 16000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_sample_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FREQ_BITS-1:0]  m_freq_q8,
    output logic signed [ROC_BITS-1:0] m_roc_q8,
    output logic                  m_stable,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_wdata
);

    localparam logic [SR_BITS-1:0]       SR_VAL        = SR_BITS'(SAMPLE_RATE);
    localparam logic [FREQ_DVD_BITS-1:0] FREQ_DIVIDEND = FREQ_DVD_BITS'(SAMPLE_RATE * 256);
    // The divider consumes its dividend from the top bit down.
    localparam logic [PROD_BITS-1:0]     FREQ_DVD_ALIGNED =
        {FREQ_DIVIDEND, {(PROD_BITS - FREQ_DVD_BITS){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVF = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIVR = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CFG_BITS-1:0]   freq_thr_reg, roc_thr_reg;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;
    logic [FREQ_BITS-1:0]  freq_reg, freq_next;
    logic [FREQ_BITS-1:0]  prev_freq_reg;
    logic [FREQ_BITS-1:0]  diff_mag_next;
    logic                  neg_reg, neg_next;
    logic [MAG_BITS-1:0]   roc_mag_reg, roc_mag_next;

    logic                  m_valid_reg, m_valid_next;
    logic [FREQ_BITS-1:0]  m_freq_reg;
    logic [ROC_BITS-1:0]   m_roc_reg;
    logic                  m_stable_reg;

    div_req_t              div_req;
    logic [PROD_BITS-1:0]  div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [PROD_BITS-1:0]  quotient;
    logic                  div_done;
    logic                  mul_start;
    logic [PROD_BITS-1:0]  product;
    logic                  mul_done;

    logic                  accept;
    logic                  out_load;
    logic [FREQ_BITS:0]    diff;
    logic [FREQ_BITS:0]    diff_neg;
    logic [CFG_BITS:0]     hi_hz;
    logic [FREQ_BITS-1:0]  hi_bound;
    logic [FREQ_BITS-1:0]  lo_bound;
    logic                  too_high, too_low, roc_bad;
    logic [ROC_BITS-1:0]   roc_signed;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // A count of zero is handled as one period of a single sample.
    assign divisor_next = (s_sample_count == '0) ? COUNT_BITS'(1) : s_sample_count;

    // The same divider serves both quotients; the frequency run starts on acceptance
    // and the rate run as soon as the product is ready. The frequency run takes the
    // divisor straight from the input, as the count register loads at the same edge.
    assign div_req.start = accept || ((state_reg == ST_MUL) && mul_done);
    assign div_req.iters = (state_reg == ST_IDLE) ? FREQ_ITERS : ROC_ITERS;
    assign div_dividend  = (state_reg == ST_IDLE) ? FREQ_DVD_ALIGNED : product;
    assign div_divisor   = (state_reg == ST_IDLE) ? divisor_next : divisor_reg;

    assign mul_start = (state_reg == ST_DIFF);

    fsmon_div #(
        .DIVISOR_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // The multiplier captures the magnitude in the same cycle that it is formed.
    fsmon_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplicand (diff_mag_next),
        .multiplier   (SR_VAL),
        .product      (product),
        .done         (mul_done)
    );

    // The frequency quotient saturates should it spill past 22 bits, which only a
    // sample rate above 16383 Hz together with a very small count can cause.
    assign freq_next = (quotient[FREQ_DVD_BITS-1:FREQ_BITS] != '0) ? FREQ_MAX
                                                                   : quotient[FREQ_BITS-1:0];

    // Signed difference against the previous frequency, split into sign and magnitude.
    assign diff          = {1'b0, freq_reg} - {1'b0, prev_freq_reg};
    assign diff_neg      = -diff;
    assign neg_next      = diff[FREQ_BITS];
    assign diff_mag_next = neg_next ? diff_neg[FREQ_BITS-1:0] : diff[FREQ_BITS-1:0];

    // The scaled magnitude saturates at the largest positive rate; truncating the
    // magnitude gives truncation toward zero once the sign is put back.
    assign roc_mag_next = (quotient[PROD_BITS-1:MAG_BITS] != '0) ? ROC_MAX
                                                                 : quotient[MAG_BITS-1:0];

    assign roc_signed = neg_reg ? -{1'b0, roc_mag_reg} : {1'b0, roc_mag_reg};

    // The stable band is open: a frequency exactly one hertz off the nominal value
    // already counts as unstable. A zero nominal value leaves only the upper bound.
    assign hi_hz    = {1'b0, freq_thr_reg} + 1'b1;
    assign hi_bound = FREQ_BITS'({hi_hz, 8'h00});
    assign lo_bound = FREQ_BITS'({freq_thr_reg - 1'b1, 8'h00});
    assign too_high = freq_reg >= hi_bound;
    assign too_low  = (freq_thr_reg != '0) && (freq_reg <= lo_bound);
    // Rate beyond the threshold in either direction is judged on the magnitude.
    assign roc_bad  = roc_mag_reg > MAG_BITS'({roc_thr_reg, 8'h00});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIVF;
                end
            end
            ST_DIVF: begin
                if (div_done) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            freq_thr_reg  <= FREQ_THR_RESET;
            roc_thr_reg   <= ROC_THR_RESET;
            prev_freq_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_FREQ_THR: freq_thr_reg <= cfg_wdata;
                    REG_ROC_THR:  roc_thr_reg  <= cfg_wdata;
                    default:      freq_thr_reg <= freq_thr_reg;
                endcase
            end
            if (out_load) begin
                prev_freq_reg <= freq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            divisor_reg <= divisor_next;
        end
        if ((state_reg == ST_DIVF) && div_done) begin
            freq_reg <= freq_next;
        end
        if (state_reg == ST_DIFF) begin
            neg_reg <= neg_next;
        end
        if ((state_reg == ST_DIVR) && div_done) begin
            roc_mag_reg <= roc_mag_next;
        end
        if (out_load) begin
            m_freq_reg   <= freq_reg;
            m_roc_reg    <= roc_signed;
            m_stable_reg <= !(too_high || too_low || roc_bad);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_freq_q8 = m_freq_reg;
    assign m_roc_q8  = m_roc_reg;
    assign m_stable  = m_stable_reg;

`ifndef SYNTHESIS
    // The divider only reports while the sequencer is waiting for one of its runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVF) || (state_reg == ST_DIVR))
        else $error("divider finished outside a divide state");

    // The multiplier only reports while the sequencer is waiting for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply state");

    // An accepted count always starts the frequency division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DIVF))
        else $error("accepted count did not start the frequency division");

    // A new result only appears from the final state of the sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the final state");
`endif

endmodule
